// File: src/micl_pkg.sv
package micl_pkg;

   // Field and register widths
   localparam int RAW_W   = 16;
   localparam int SCALE_W = 16;
   localparam int BIAS_W  = 24;
   localparam int ROW_W   = 48;
   localparam int COEF_W  = 16;
   localparam int FIELD_W = 24;
   localparam int AXES    = 3;

   // Internal datapath widths
   localparam int PROD_W   = RAW_W + SCALE_W + 1;   // signed raw * unsigned scale
   localparam int SHIFT_W  = PROD_W - 10;           // after floor shift by 10
   localparam int DIFF_W   = BIAS_W + 1;            // scaled minus bias
   localparam int TERM_W   = COEF_W + DIFF_W;       // coefficient times diff
   localparam int SUM_W    = TERM_W + 2;            // sum of three terms
   localparam int RES_W    = SUM_W - 14;            // after floor shift by 14

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] REG_SCALE   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS_X  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS_Y  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BIAS_Z  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_NEGATE  = 4'd7;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd9830;
   localparam logic [ROW_W-1:0]   ROW0_RESET  = 48'h0000_0000_4000;
   localparam logic [ROW_W-1:0]   ROW1_RESET  = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0]   ROW2_RESET  = 48'h4000_0000_0000;

   // Saturation rails, symmetric so negation cannot overflow
   localparam logic signed [RES_W-1:0]   RES_MAX   = 29'sd8388607;
   localparam logic signed [RES_W-1:0]   RES_MIN   = -29'sd8388607;
   localparam logic signed [FIELD_W-1:0] FIELD_MAX = 24'sd8388607;
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = -24'sd8388607;

   typedef struct packed {
      logic [SCALE_W-1:0]             scale;
      logic [AXES-1:0][BIAS_W-1:0]    bias;
      logic [AXES-1:0][ROW_W-1:0]     row;
      logic [AXES-1:0]                negate;
   } cfg_type;

   typedef logic [AXES-1:0][DIFF_W-1:0] diff_vec_type;

endpackage

// File: src/micl_if.sv
interface micl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 ready_req;
   logic signed [micl_pkg::RAW_W-1:0]    raw_x;
   logic signed [micl_pkg::RAW_W-1:0]    raw_y;
   logic signed [micl_pkg::RAW_W-1:0]    raw_z;

   modport source (output valid, ready_req, raw_x, raw_y, raw_z, input ready);
   modport sink (input valid, ready_req, raw_x, raw_y, raw_z, output ready);
endinterface

interface micl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [micl_pkg::FIELD_W-1:0]  field_x;
   logic signed [micl_pkg::FIELD_W-1:0]  field_y;
   logic signed [micl_pkg::FIELD_W-1:0]  field_z;
   logic                                 clipped;

   modport source (output valid, field_x, field_y, field_z, clipped, input ready);
   modport sink (input valid, field_x, field_y, field_z, clipped, output ready);
endinterface

// File: src/micl_regs.sv
module micl_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [micl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [micl_pkg::CSR_DATA_W-1:0]      csr_data,
   output micl_pkg::cfg_type                    cfg
);

   micl_pkg::cfg_type cfg_ff, cfg_in;

   // Decode a write; bits above a register's width and unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            micl_pkg::REG_SCALE:  cfg_in.scale   = csr_data[micl_pkg::SCALE_W-1:0];
            micl_pkg::REG_BIAS_X: cfg_in.bias[0] = csr_data[micl_pkg::BIAS_W-1:0];
            micl_pkg::REG_BIAS_Y: cfg_in.bias[1] = csr_data[micl_pkg::BIAS_W-1:0];
            micl_pkg::REG_BIAS_Z: cfg_in.bias[2] = csr_data[micl_pkg::BIAS_W-1:0];
            micl_pkg::REG_ROW0:   cfg_in.row[0]  = csr_data[micl_pkg::ROW_W-1:0];
            micl_pkg::REG_ROW1:   cfg_in.row[1]  = csr_data[micl_pkg::ROW_W-1:0];
            micl_pkg::REG_ROW2:   cfg_in.row[2]  = csr_data[micl_pkg::ROW_W-1:0];
            micl_pkg::REG_NEGATE: cfg_in.negate  = csr_data[micl_pkg::AXES-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale  <= micl_pkg::SCALE_RESET;
         cfg_ff.bias   <= '0;
         cfg_ff.row[0] <= micl_pkg::ROW0_RESET;
         cfg_ff.row[1] <= micl_pkg::ROW1_RESET;
         cfg_ff.row[2] <= micl_pkg::ROW2_RESET;
         cfg_ff.negate <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/micl_scale_lane.sv
module micl_scale_lane (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic signed [micl_pkg::RAW_W-1:0]    raw,
   input  logic [micl_pkg::SCALE_W-1:0]         scale,
   input  logic [micl_pkg::BIAS_W-1:0]          bias,
   output logic signed [micl_pkg::DIFF_W-1:0]   diff
);

   logic signed [micl_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [micl_pkg::SHIFT_W-1:0] scaled;
   logic signed [micl_pkg::DIFF_W-1:0]  diff_ff, diff_in;

   // Scale raw count to 1/64 uT
   assign prod_in = raw * $signed({1'b0, scale});

   // Floor shift by 10, then remove hard-iron bias at full width
   assign scaled  = prod_ff[micl_pkg::PROD_W-1:10];
   assign diff_in = $signed({{(micl_pkg::DIFF_W-micl_pkg::SHIFT_W){scaled[micl_pkg::SHIFT_W-1]}},
                             scaled})
                  - $signed({bias[micl_pkg::BIAS_W-1], bias});

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         diff_ff <= diff_in;
      end
   end

   assign diff = diff_ff;

endmodule

// File: src/micl_row_lane.sv
module micl_row_lane (
   input  logic                                 clock,
   input  logic                                 advance,
   input  micl_pkg::diff_vec_type               diff,
   input  logic [micl_pkg::ROW_W-1:0]           row,
   input  logic                                 negate,
   output logic signed [micl_pkg::FIELD_W-1:0]  field,
   output logic                                 clip
);

   logic signed [micl_pkg::TERM_W-1:0] term_ff [micl_pkg::AXES];
   logic signed [micl_pkg::TERM_W-1:0] term_in [micl_pkg::AXES];
   logic signed [micl_pkg::SUM_W-1:0]  sum;
   logic signed [micl_pkg::RES_W-1:0]  res;
   logic signed [micl_pkg::FIELD_W-1:0] sat;

   // One soft-iron product per input axis
   always_comb begin
      for (int k = 0; k < micl_pkg::AXES; k++) begin
         term_in[k] = $signed(row[k*micl_pkg::COEF_W +: micl_pkg::COEF_W])
                    * $signed(diff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < micl_pkg::AXES; k++) begin
            term_ff[k] <= term_in[k];
         end
      end
   end

   // Sum, floor shift by 14, clamp to the symmetric rails, apply sign
   assign sum = $signed({{2{term_ff[0][micl_pkg::TERM_W-1]}}, term_ff[0]})
              + $signed({{2{term_ff[1][micl_pkg::TERM_W-1]}}, term_ff[1]})
              + $signed({{2{term_ff[2][micl_pkg::TERM_W-1]}}, term_ff[2]});
   assign res = sum[micl_pkg::SUM_W-1:14];

   always_comb begin
      clip = 1'b0;
      sat  = res[micl_pkg::FIELD_W-1:0];
      if (res > micl_pkg::RES_MAX) begin
         sat  = micl_pkg::FIELD_MAX;
         clip = 1'b1;
      end else if (res < micl_pkg::RES_MIN) begin
         sat  = micl_pkg::FIELD_MIN;
         clip = 1'b1;
      end
   end

   assign field = negate ? -sat : sat;

endmodule

// File: src/magnetometer_iron_calibration_unit.sv
// Magnetometer hard-iron / soft-iron calibration unit.
// Input channel req_bus carries one three-axis raw sample per word plus a
// data-ready flag; a word whose flag is clear is taken and gives no result.
// Output channel rsp_bus carries the corrected field per axis in 1/64 uT and
// a clipped flag set when any axis was clamped to the +/-8388607 rail.
// Configuration goes through csr_write/csr_index/csr_data, one register per
// write; write only while no sample is in flight. Unknown indexes are ignored.
// A sample passes the product, difference, term and output registers.
// Throughput: one sample per cycle while not stalled; three scaling lanes and
// three matrix-row lanes run side by side, each multiply followed by a
// register, and the row lanes merge in the output register.
// Stall: the whole pipeline holds while a result waits on rsp_bus, so
// req_bus.ready follows "output empty or being taken".
// Reset: synchronous, clears all pipeline valid bits and loads the register
// defaults (scale 0.15 uT/count, zero bias, identity matrix, no negation).
module magnetometer_iron_calibration_unit (
   input  logic                               clock,
   input  logic                               reset,
   micl_req_if.sink                           req_bus,
   micl_rsp_if.source                         rsp_bus,
   input  logic                               csr_write,
   input  logic [micl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [micl_pkg::CSR_DATA_W-1:0]    csr_data
);

   micl_pkg::cfg_type      cfg;
   micl_pkg::diff_vec_type diff;
   logic                   advance;
   logic                   prod_vld_ff, diff_vld_ff, term_vld_ff, out_vld_ff;
   logic signed [micl_pkg::RAW_W-1:0]   raw [micl_pkg::AXES];
   logic signed [micl_pkg::FIELD_W-1:0] field [micl_pkg::AXES];
   logic [micl_pkg::AXES-1:0]           clip;
   logic signed [micl_pkg::FIELD_W-1:0] fx_ff, fy_ff, fz_ff;
   logic                                clipped_ff;

   micl_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Advance the pipeline unless a result is stuck at the output
   assign advance       = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = advance && !reset;

   assign raw[0] = req_bus.raw_x;
   assign raw[1] = req_bus.raw_y;
   assign raw[2] = req_bus.raw_z;

   for (genvar a = 0; a < micl_pkg::AXES; a++) begin : g_lane
      micl_scale_lane u_scale (
         .clock   (clock),
         .advance (advance),
         .raw     (raw[a]),
         .scale   (cfg.scale),
         .bias    (cfg.bias[a]),
         .diff    (diff[a])
      );

      micl_row_lane u_row (
         .clock   (clock),
         .advance (advance),
         .diff    (diff),
         .row     (cfg.row[a]),
         .negate  (cfg.negate[a]),
         .field   (field[a]),
         .clip    (clip[a])
      );
   end

   // Track valid words; drop samples without the data-ready flag
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         diff_vld_ff <= 1'b0;
         term_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else if (advance) begin
         prod_vld_ff <= req_bus.valid && req_bus.ready_req;
         diff_vld_ff <= prod_vld_ff;
         term_vld_ff <= diff_vld_ff;
         out_vld_ff  <= term_vld_ff;
      end
   end

   // Merge the row lanes into the output register
   always_ff @(posedge clock) begin
      if (advance) begin
         fx_ff      <= field[0];
         fy_ff      <= field[1];
         fz_ff      <= field[2];
         clipped_ff <= |clip;
      end
   end

   assign rsp_bus.valid   = out_vld_ff;
   assign rsp_bus.field_x = fx_ff;
   assign rsp_bus.field_y = fy_ff;
   assign rsp_bus.field_z = fz_ff;
   assign rsp_bus.clipped = clipped_ff;

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_bus.valid)
      else $error("output valid after reset");

   a_clip_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.clipped) |->
         (rsp_bus.field_x == micl_pkg::FIELD_MAX || rsp_bus.field_x == micl_pkg::FIELD_MIN ||
          rsp_bus.field_y == micl_pkg::FIELD_MAX || rsp_bus.field_y == micl_pkg::FIELD_MIN ||
          rsp_bus.field_z == micl_pkg::FIELD_MAX || rsp_bus.field_z == micl_pkg::FIELD_MIN))
      else $error("clipped set but no axis on a rail");

   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.field_x != 24'sh800000 && rsp_bus.field_y != 24'sh800000 &&
                         rsp_bus.field_z != 24'sh800000))
      else $error("field outside symmetric range");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(diff) && $stable(term_vld_ff))
      else $error("pipeline moved during stall");
`endif

endmodule
